// ===== sv/cdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdrc_pkg
// Shared widths, codes and types of the calibrated DAC ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrc_pkg;

  localparam int OPCODE_W    = 3;
  localparam int DURATION_W  = 16;
  localparam int DAC_WORD_W  = 24;
  localparam int GAIN_W      = 22;
  localparam int OFFSET_W    = 23;
  localparam int CAP_W       = 20;
  localparam int PERIOD_W    = 8;
  localparam int COUNT_W     = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;
  localparam int ITER_W      = 6;

  // Command opcodes.
  localparam logic [OPCODE_W-1:0] OP_SET_POWER = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_LIMIT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_HEAT_UP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_COOL_DOWN = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_POWER   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_POWER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOFT_CAP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_PERIOD  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOL_PERIOD  = 3'd6;

  // Ramp modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_COOL = 2'd2;

  // Code limits.
  localparam logic [9:0]         PWR_FULL     = 10'h3FF;
  localparam logic [9:0]         PWR_SENTINEL = 10'h3F0;
  localparam logic [7:0]         LIM_FULL     = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 14'h3FFF;

  // Shared arithmetic unit operations.
  localparam logic [1:0] ENG_MUL = 2'd0;
  localparam logic [1:0] ENG_DIV = 2'd1;
  localparam logic [1:0] ENG_ADD = 2'd2;
  localparam logic [1:0] ENG_SUB = 2'd3;

  localparam logic [ITER_W-1:0] ITERS_GAIN_MUL = 6'd22;
  localparam logic [ITER_W-1:0] ITERS_CNT_DIV  = 6'd18;
  localparam logic [ITER_W-1:0] ITERS_RAMP_MUL = 6'd14;
  localparam logic [ITER_W-1:0] ITERS_ONE      = 6'd1;

  typedef struct packed {
    logic              start;
    logic [1:0]        op;
    logic [ITER_W-1:0] iters;
  } eng_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

`default_nettype wire

// ===== sv/cdrc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cdrc_cmd_if
// Command channel: opcode, voltage and ramp duration with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdrc_cmd_if import cdrc_pkg::*; #(
  parameter int VOLT_BITS = 20
) ();
  logic                        valid;
  logic                        ready;
  logic [OPCODE_W-1:0]         opcode;
  logic signed [VOLT_BITS-1:0] volts;
  logic [DURATION_W-1:0]       duration_ms;

  modport source (output valid, output opcode, output volts, output duration_ms,
                  input ready);
  modport sink (input valid, input opcode, input volts, input duration_ms,
                output ready);
endinterface

`default_nettype wire

// ===== sv/cdrc_res_if.sv =====
// ----------------------------------------------------------------------------
// cdrc_res_if
// Result channel: packed DAC word, last requests and ramp status.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdrc_res_if import cdrc_pkg::*; #(
  parameter int VOLT_BITS = 20
) ();
  logic                        valid;
  logic                        ready;
  logic [DAC_WORD_W-1:0]       dac_word;
  logic signed [VOLT_BITS-1:0] requested_power;
  logic signed [VOLT_BITS-1:0] requested_limit;
  logic                        ramp_busy;

  modport source (output valid, output dac_word, output requested_power,
                  output requested_limit, output ramp_busy, input ready);
  modport sink (input valid, input dac_word, input requested_power,
                input requested_limit, input ramp_busy, output ready);
endinterface

`default_nettype wire

// ===== sv/calibrated_dac_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// calibrated_dac_ramp_controller
// Two-channel calibrated DAC driver with soft-start heat and cool ramps.
// ----------------------------------------------------------------------------
// Sequence: a set command runs the gain multiply and then the offset add; a tick
// that writes the ramp runs the ramp multiply, the gain multiply and the offset
// add; a ramp start runs the count divide, the step divide and the sign add, all
// on the one shared arithmetic unit. One command at a time.
// Synchronous reset loads the register defaults and stops any ramp.
`default_nettype none

module calibrated_dac_ramp_controller import cdrc_pkg::*; #(
  parameter int VOLT_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  cdrc_cmd_if.sink                    cmd,
  cdrc_res_if.source                  res
);

  localparam int QW   = VOLT_BITS + 12;
  localparam int SW   = VOLT_BITS + 13;
  localparam int CAPW = (VOLT_BITS > CAP_W) ? VOLT_BITS : CAP_W;
  localparam int W    = (VOLT_BITS + 28 > 43) ? VOLT_BITS + 28 : 43;
  localparam int CW   = W - 24;

  localparam logic [W-1:0] ROUND_HALF = {{(W-24){1'b0}}, 1'b1, 23'd0};

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MAP_MUL   = 4'd1;
  localparam logic [3:0] S_MAP_ADD   = 4'd2;
  localparam logic [3:0] S_CNT_DIV   = 4'd3;
  localparam logic [3:0] S_STEP_DIV  = 4'd4;
  localparam logic [3:0] S_STEP_SIGN = 4'd5;
  localparam logic [3:0] S_RAMP_MUL  = 4'd6;
  localparam logic [3:0] S_EMIT      = 4'd7;

  // Configuration registers.
  logic [GAIN_W-1:0]          gain_power;
  logic signed [OFFSET_W-1:0] offset_power;
  logic [GAIN_W-1:0]          gain_limit;
  logic signed [OFFSET_W-1:0] offset_limit;
  logic signed [CAP_W-1:0]    soft_cap_volts;
  logic [PERIOD_W-1:0]        heat_period_ms;
  logic [PERIOD_W-1:0]        cool_period_ms;

  // Block state.
  logic [3:0]                  state;
  logic [DAC_WORD_W-1:0]       dac_word_store;
  logic signed [VOLT_BITS-1:0] last_power_volts;
  logic signed [VOLT_BITS-1:0] last_limit_volts;
  logic [1:0]                  ramp_mode;
  logic [COUNT_W-1:0]          ramp_index;
  logic [COUNT_W-1:0]          ramp_count;
  logic signed [SW-1:0]        ramp_step;
  logic [PERIOD_W-1:0]         tick_count;
  logic [1:0]                  pend_mode;
  logic signed [VOLT_BITS-1:0] target;
  logic                        map_limit;

  // Result register.
  logic                        res_valid;
  logic [DAC_WORD_W-1:0]       res_word;
  logic signed [VOLT_BITS-1:0] res_power;
  logic signed [VOLT_BITS-1:0] res_limit;
  logic                        res_busy;

  // Shared unit connections.
  eng_req_t      eng_req;
  eng_stat_t     eng_stat;
  logic [W-1:0]  eng_init;
  logic [W-1:0]  eng_a;
  logic [QW-1:0] eng_b;
  logic [W-1:0]  eng_acc;
  logic [QW-1:0] eng_quo;

  logic                        cmd_xfer;
  logic signed [CAPW-1:0]      cap_in;
  logic signed [CAPW-1:0]      lim_in;
  logic [PERIOD_W-1:0]         start_period;
  logic [PERIOD_W-1:0]         start_p;
  logic [17:0]                 cnt_num;
  logic [PERIOD_W-1:0]         tick_p;
  logic [PERIOD_W-1:0]         tick_inc;
  logic                        tick_fire;
  logic signed [VOLT_BITS-1:0] ramp_v;
  logic signed [CAPW-1:0]      ramp_cap;
  logic [17:0]                 cnt_q;
  logic [COUNT_W-1:0]          cnt_sat;
  logic                        target_neg;
  logic [VOLT_BITS-1:0]        target_mag;
  logic signed [OFFSET_W-1:0]  off_sel;
  logic signed [W-13:0]        off_ext;
  logic [CW-1:0]               code_full;
  logic [9:0]                  pwr_clip;
  logic [9:0]                  pwr_code;
  logic [7:0]                  lim_code;

  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    eff_period = (p == '0) ? PERIOD_W'(1) : p;
  endfunction

  function automatic logic signed [CAPW-1:0] cap_power(
      input logic signed [VOLT_BITS-1:0] v,
      input logic signed [CAP_W-1:0]     cap);
    logic signed [CAPW-1:0] vx;
    logic signed [CAPW-1:0] cx;
    vx = CAPW'(v);
    cx = CAPW'(cap);
    cap_power = (vx > cx) ? cx : vx;
  endfunction

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE) && !eng_stat.busy;

  assign cap_in       = cap_power(cmd.volts, soft_cap_volts);
  assign lim_in       = CAPW'(cmd.volts);
  assign start_period = (cmd.opcode == OP_HEAT_UP) ? heat_period_ms : cool_period_ms;
  assign start_p      = eff_period(start_period);
  assign cnt_num      = 18'({cmd.duration_ms, 1'b0}) + 18'({start_p, 1'b0}) + 18'(start_p);

  assign tick_p    = eff_period((ramp_mode == MODE_HEAT) ? heat_period_ms : cool_period_ms);
  assign tick_inc  = tick_count + PERIOD_W'(1);
  assign tick_fire = (tick_inc >= tick_p);

  // The product step*index is Q.12; dropping 12 bits floors it.
  assign ramp_v   = eng_acc[VOLT_BITS+11:12];
  assign ramp_cap = cap_power(ramp_v, soft_cap_volts);

  assign cnt_q   = eng_quo[17:0];
  assign cnt_sat = (cnt_q > 18'(COUNT_MAX)) ? COUNT_MAX :
                   (cnt_q == '0) ? COUNT_W'(1) : cnt_q[COUNT_W-1:0];

  assign target_neg = target[VOLT_BITS-1];
  assign target_mag = target_neg ? VOLT_BITS'(-target) : VOLT_BITS'(target);

  assign off_sel = map_limit ? offset_limit : offset_power;
  assign off_ext = (W-12)'(off_sel);

  // Floor of the Q.24 sum, then clamped to each channel's code range.
  assign code_full = eng_acc[W-1:24];

  always_comb begin
    pwr_clip = (|code_full[CW-2:10]) ? PWR_FULL : code_full[9:0];
    if (code_full[CW-1]) begin
      pwr_code = '0;
    end else if (pwr_clip > PWR_SENTINEL) begin
      pwr_code = PWR_SENTINEL;
    end else begin
      pwr_code = pwr_clip;
    end
    if (code_full[CW-1]) begin
      lim_code = '0;
    end else if (|code_full[CW-2:8]) begin
      lim_code = LIM_FULL;
    end else begin
      lim_code = code_full[7:0];
    end
  end

  always_comb begin
    eng_req  = '0;
    eng_init = '0;
    eng_a    = '0;
    eng_b    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          unique case (cmd.opcode)
            OP_SET_POWER: begin
              eng_req  = '{start: 1'b1, op: ENG_MUL, iters: ITERS_GAIN_MUL};
              eng_init = ROUND_HALF;
              eng_a    = W'(cap_in);
              eng_b    = QW'(gain_power);
            end
            OP_SET_LIMIT: begin
              eng_req  = '{start: 1'b1, op: ENG_MUL, iters: ITERS_GAIN_MUL};
              eng_init = ROUND_HALF;
              eng_a    = W'(lim_in);
              eng_b    = QW'(gain_limit);
            end
            OP_HEAT_UP, OP_COOL_DOWN: begin
              eng_req = '{start: 1'b1, op: ENG_DIV, iters: ITERS_CNT_DIV};
              eng_a   = W'({start_p, 1'b0});
              eng_b   = {cnt_num, {(QW-18){1'b0}}};
            end
            OP_TICK: begin
              if (ramp_mode != MODE_IDLE && tick_fire) begin
                eng_req = '{start: 1'b1, op: ENG_MUL, iters: ITERS_RAMP_MUL};
                eng_a   = W'(ramp_step);
                eng_b   = QW'(ramp_index);
              end
            end
            default: begin
              eng_req = '0;
            end
          endcase
        end
      end
      S_MAP_MUL: begin
        if (eng_stat.done) begin
          eng_req  = '{start: 1'b1, op: ENG_ADD, iters: ITERS_ONE};
          eng_init = eng_acc;
          eng_a    = {off_ext, 12'd0};
        end
      end
      S_CNT_DIV: begin
        if (eng_stat.done) begin
          eng_req = '{start: 1'b1, op: ENG_DIV, iters: ITER_W'(QW)};
          eng_a   = W'(cnt_sat);
          eng_b   = {target_mag, 12'd0};
        end
      end
      S_STEP_DIV: begin
        if (eng_stat.done) begin
          eng_req = '{start: 1'b1, op: (target_neg ? ENG_SUB : ENG_ADD), iters: ITERS_ONE};
          eng_a   = W'(eng_quo);
        end
      end
      S_RAMP_MUL: begin
        if (eng_stat.done) begin
          eng_req  = '{start: 1'b1, op: ENG_MUL, iters: ITERS_GAIN_MUL};
          eng_init = ROUND_HALF;
          eng_a    = W'(ramp_cap);
          eng_b    = QW'(gain_power);
        end
      end
      default: begin
        eng_req = '0;
      end
    endcase
  end

  cdrc_engine #(
    .W  (W),
    .QW (QW)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .req  (eng_req),
    .init (eng_init),
    .opa  (eng_a),
    .opb  (eng_b),
    .stat (eng_stat),
    .acc  (eng_acc),
    .quo  (eng_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_power       <= GAIN_W'(4096);
      offset_power     <= '0;
      gain_limit       <= GAIN_W'(4096);
      offset_limit     <= '0;
      soft_cap_volts   <= CAP_W'(524287);
      heat_period_ms   <= PERIOD_W'(5);
      cool_period_ms   <= PERIOD_W'(10);
      state            <= S_IDLE;
      dac_word_store   <= '0;
      last_power_volts <= '0;
      last_limit_volts <= '0;
      ramp_mode        <= MODE_IDLE;
      ramp_index       <= '0;
      ramp_count       <= '0;
      ramp_step        <= '0;
      tick_count       <= '0;
      pend_mode        <= MODE_IDLE;
      map_limit        <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (res.ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_GAIN_POWER:   gain_power     <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET_POWER: offset_power   <= cfg_data[OFFSET_W-1:0];
          CFG_GAIN_LIMIT:   gain_limit     <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET_LIMIT: offset_limit   <= cfg_data[OFFSET_W-1:0];
          CFG_SOFT_CAP:     soft_cap_volts <= cfg_data[CAP_W-1:0];
          CFG_HEAT_PERIOD:  heat_period_ms <= cfg_data[PERIOD_W-1:0];
          CFG_COOL_PERIOD:  cool_period_ms <= cfg_data[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            unique case (cmd.opcode)
              OP_SET_POWER: begin
                ramp_mode        <= MODE_IDLE;
                ramp_index       <= '0;
                tick_count       <= '0;
                last_power_volts <= cmd.volts;
                map_limit        <= 1'b0;
                state            <= S_MAP_MUL;
              end
              OP_SET_LIMIT: begin
                ramp_mode        <= MODE_IDLE;
                ramp_index       <= '0;
                tick_count       <= '0;
                last_limit_volts <= cmd.volts;
                map_limit        <= 1'b1;
                state            <= S_MAP_MUL;
              end
              OP_HEAT_UP: begin
                ramp_mode  <= MODE_IDLE;
                ramp_index <= '0;
                tick_count <= '0;
                target     <= cmd.volts;
                pend_mode  <= MODE_HEAT;
                state      <= S_CNT_DIV;
              end
              OP_COOL_DOWN: begin
                ramp_mode  <= MODE_IDLE;
                ramp_index <= '0;
                tick_count <= '0;
                target     <= last_power_volts;
                pend_mode  <= MODE_COOL;
                state      <= S_CNT_DIV;
              end
              OP_TICK: begin
                if (ramp_mode != MODE_IDLE) begin
                  if (tick_fire) begin
                    // The multiply has latched the current index; advance now
                    // so the result shows whether further steps remain.
                    tick_count <= '0;
                    if (ramp_mode == MODE_HEAT) begin
                      if (ramp_index >= ramp_count) begin
                        ramp_mode <= MODE_IDLE;
                      end else begin
                        ramp_index <= ramp_index + COUNT_W'(1);
                      end
                    end else begin
                      if (ramp_index == '0) begin
                        ramp_mode <= MODE_IDLE;
                      end else begin
                        ramp_index <= ramp_index - COUNT_W'(1);
                      end
                    end
                    state <= S_RAMP_MUL;
                  end else begin
                    tick_count <= tick_inc;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MAP_MUL: begin
          if (eng_stat.done) begin
            state <= S_MAP_ADD;
          end
        end
        S_MAP_ADD: begin
          if (eng_stat.done) begin
            if (map_limit) begin
              dac_word_store[23:16] <= lim_code;
            end else begin
              dac_word_store[9:0] <= {pwr_code[1:0], pwr_code[9:2]};
            end
            state <= S_EMIT;
          end
        end
        S_CNT_DIV: begin
          if (eng_stat.done) begin
            ramp_count <= cnt_sat;
            state      <= S_STEP_DIV;
          end
        end
        S_STEP_DIV: begin
          if (eng_stat.done) begin
            state <= S_STEP_SIGN;
          end
        end
        S_STEP_SIGN: begin
          if (eng_stat.done) begin
            ramp_step  <= eng_acc[SW-1:0];
            ramp_mode  <= pend_mode;
            ramp_index <= (pend_mode == MODE_HEAT) ? COUNT_W'(1) : ramp_count - COUNT_W'(1);
            tick_count <= '0;
            state      <= S_IDLE;
          end
        end
        S_RAMP_MUL: begin
          if (eng_stat.done) begin
            last_power_volts <= ramp_v;
            map_limit        <= 1'b0;
            state            <= S_MAP_MUL;
          end
        end
        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!res_valid || res.ready)) begin
      res_word  <= dac_word_store;
      res_power <= last_power_volts;
      res_limit <= last_limit_volts;
      res_busy  <= (ramp_mode != MODE_IDLE);
    end
  end

  assign res.valid           = res_valid;
  assign res.dac_word        = res_word;
  assign res.requested_power = res_power;
  assign res.requested_limit = res_limit;
  assign res.ramp_busy       = res_busy;

endmodule

`default_nettype wire

// ===== sv/cdrc_engine.sv =====
// ----------------------------------------------------------------------------
// cdrc_engine
// Shared iterative unit: shift-add multiply, restoring divide, add, subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrc_engine import cdrc_pkg::*; #(
  parameter int W  = 48,
  parameter int QW = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire eng_req_t       req,
  input  wire logic [W-1:0]   init,
  input  wire logic [W-1:0]   opa,
  input  wire logic [QW-1:0]  opb,
  output eng_stat_t           stat,
  output logic [W-1:0]        acc,
  output logic [QW-1:0]       quo
);

  logic [W-1:0]      mcand;
  logic [QW-1:0]     shreg;
  logic [1:0]        op;
  logic [ITER_W-1:0] cnt;
  logic              done;

  logic [W-1:0]  add_x;
  logic [W-1:0]  add_y;
  logic          add_sub;
  logic [W:0]    add_sum;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  mcand_next;
  logic [QW-1:0] shreg_next;

  // The one adder of the unit; bit W is the carry, which for a subtract
  // means the minuend was not below the subtrahend.
  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+1)'(add_sub);

  always_comb begin
    add_x      = acc;
    add_y      = mcand;
    add_sub    = 1'b0;
    acc_next   = acc;
    mcand_next = mcand;
    shreg_next = shreg;
    unique case (op)
      ENG_MUL: begin
        if (shreg[0]) begin
          acc_next = add_sum[W-1:0];
        end
        mcand_next = {mcand[W-2:0], 1'b0};
        shreg_next = {1'b0, shreg[QW-1:1]};
      end
      ENG_DIV: begin
        add_x      = {acc[W-2:0], shreg[QW-1]};
        add_sub    = 1'b1;
        acc_next   = add_sum[W] ? add_sum[W-1:0] : add_x;
        shreg_next = {shreg[QW-2:0], add_sum[W]};
      end
      ENG_ADD: begin
        acc_next = add_sum[W-1:0];
      end
      ENG_SUB: begin
        add_sub  = 1'b1;
        acc_next = add_sum[W-1:0];
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= req.iters;
      end else if (cnt != '0) begin
        cnt  <= cnt - ITER_W'(1);
        done <= (cnt == ITER_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= init;
      mcand <= opa;
      shreg <= opb;
      op    <= req.op;
    end else if (cnt != '0) begin
      acc   <= acc_next;
      mcand <= mcand_next;
      shreg <= shreg_next;
    end
  end

  assign quo       = shreg;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== tb/sv/cdrc_update_checker.sv =====
// ----------------------------------------------------------------------------
// cdrc_update_checker
// Watches the command, result and register-write ports of the DAC ramp
// controller, keeps its own copy of the channel and ramp state, works out the
// DAC update that each command should produce and compares it field by field
// with the result channel in order.
// ----------------------------------------------------------------------------
module cdrc_update_checker import cdrc_pkg::*; #(
  parameter int VOLT_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cdrc_cmd_if                    cmd,
  cdrc_res_if                    res,
  output int                     mismatch_count,
  output int                     updates_waiting
);

  typedef struct packed {
    logic [DAC_WORD_W-1:0] dac_word;
    logic [VOLT_BITS-1:0]  power_req;
    logic [VOLT_BITS-1:0]  limit_req;
    logic                  busy;
  } dac_update_t;

  dac_update_t pending_updates[$];

  // Calibration and ramp timing registers.
  longint gain_pwr, off_pwr, gain_lim, off_lim, cap_volts, heat_per, cool_per;

  // Channel and ramp state.
  logic [DAC_WORD_W-1:0] word_q;
  longint                last_pwr, last_lim, step_q, idx_q, count_q;
  logic [1:0]            mode_q;
  logic [7:0]            tick_q;

  int errors = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < 100)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void load_defaults();
    gain_pwr  = 4096;
    off_pwr   = 0;
    gain_lim  = 4096;
    off_lim   = 0;
    cap_volts = 524287;
    heat_per  = 5;
    cool_per  = 10;
    word_q    = '0;
    last_pwr  = 0;
    last_lim  = 0;
    mode_q    = MODE_IDLE;
    idx_q     = 0;
    count_q   = 0;
    step_q    = 0;
    tick_q    = '0;
  endfunction

  function automatic void store_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN_POWER:   gain_pwr  = longint'(data[GAIN_W-1:0]);
      CFG_OFFSET_POWER: off_pwr   = longint'($signed(data[OFFSET_W-1:0]));
      CFG_GAIN_LIMIT:   gain_lim  = longint'(data[GAIN_W-1:0]);
      CFG_OFFSET_LIMIT: off_lim   = longint'($signed(data[OFFSET_W-1:0]));
      CFG_SOFT_CAP:     cap_volts = longint'($signed(data[CAP_W-1:0]));
      CFG_HEAT_PERIOD:  heat_per  = longint'(data[PERIOD_W-1:0]);
      CFG_COOL_PERIOD:  cool_per  = longint'(data[PERIOD_W-1:0]);
      default: ;
    endcase
  endfunction

  // Product is Q.24, the offset is moved up to Q.24 and half a code rounds.
  function automatic longint volts_to_code(longint v, longint gain, longint offset,
                                           longint full);
    longint acc;
    acc = v * gain + offset * 4096 + (longint'(1) <<< 23);
    acc = acc >>> 24;
    if (acc > full)
      return full;
    if (acc < 0)
      return 0;
    return acc;
  endfunction

  function automatic void load_power(longint v);
    longint code;
    last_pwr = v;
    if (v > cap_volts)
      v = cap_volts;
    code = volts_to_code(v, gain_pwr, off_pwr, longint'(PWR_FULL));
    if (code > longint'(PWR_SENTINEL))
      code = longint'(PWR_SENTINEL);
    word_q[7:0] = code[9:2];
    word_q[9:8] = code[1:0];
  endfunction

  function automatic void load_limit(longint v);
    longint code;
    last_lim = v;
    code = volts_to_code(v, gain_lim, off_lim, longint'(LIM_FULL));
    word_q[23:16] = code[7:0];
  endfunction

  function automatic void arm_ramp(logic [1:0] mode, longint target, longint ms,
                                   longint per);
    longint p, n;
    p = (per == 0) ? 1 : per;
    n = (2 * ms + 3 * p) / (2 * p);
    if (n > longint'(COUNT_MAX))
      n = longint'(COUNT_MAX);
    if (n == 0)
      n = 1;
    count_q = n;
    step_q  = (target * 4096) / n;
    mode_q  = mode;
    idx_q   = (mode == MODE_HEAT) ? 1 : n - 1;
    tick_q  = '0;
  endfunction

  // Returns 1 when the command produces a DAC update, which is then in upd.
  function automatic bit predict_update(logic [OPCODE_W-1:0] op, longint v, longint ms,
                                        output dac_update_t upd);
    longint per;
    upd = '0;
    if (op <= OP_COOL_DOWN) begin
      mode_q = MODE_IDLE;
      idx_q  = 0;
      tick_q = '0;
    end
    case (op)
      OP_SET_POWER: load_power(v);
      OP_SET_LIMIT: load_limit(v);
      OP_HEAT_UP: begin
        arm_ramp(MODE_HEAT, v, ms, heat_per);
        return 1'b0;
      end
      OP_COOL_DOWN: begin
        arm_ramp(MODE_COOL, last_pwr, ms, cool_per);
        return 1'b0;
      end
      OP_TICK: begin
        if (mode_q == MODE_IDLE)
          return 1'b0;
        per = (mode_q == MODE_HEAT) ? heat_per : cool_per;
        if (per == 0)
          per = 1;
        tick_q = tick_q + 8'd1;
        if (longint'(tick_q) < per)
          return 1'b0;
        tick_q = '0;
        load_power((step_q * idx_q) >>> 12);
        if (mode_q == MODE_HEAT) begin
          if (idx_q >= count_q)
            mode_q = MODE_IDLE;
          else
            idx_q++;
        end else begin
          if (idx_q == 0)
            mode_q = MODE_IDLE;
          else
            idx_q--;
        end
      end
      default: return 1'b0;
    endcase
    upd.dac_word  = word_q;
    upd.power_req = last_pwr[VOLT_BITS-1:0];
    upd.limit_req = last_lim[VOLT_BITS-1:0];
    upd.busy      = (mode_q != MODE_IDLE);
    return 1'b1;
  endfunction

  // A result always belongs to an earlier command, so it is checked before
  // the command transfer of the same edge is predicted.
  always @(posedge clk) begin
    dac_update_t seen, want;
    if (rst) begin
      load_defaults();
      pending_updates.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen.dac_word  = res.dac_word;
        seen.power_req = res.requested_power;
        seen.limit_req = res.requested_limit;
        seen.busy      = res.ramp_busy;
        if (pending_updates.size() == 0) begin
          report_mismatch("unexpected result dac_word", seen.dac_word, 0);
        end else begin
          want = pending_updates.pop_front();
          if (seen.dac_word !== want.dac_word)
            report_mismatch("dac_word", seen.dac_word, want.dac_word);
          if (seen.power_req !== want.power_req)
            report_mismatch("requested_power", seen.power_req, want.power_req);
          if (seen.limit_req !== want.limit_req)
            report_mismatch("requested_limit", seen.limit_req, want.limit_req);
          if (seen.busy !== want.busy)
            report_mismatch("ramp_busy", seen.busy, want.busy);
        end
      end
      if (cfg_wr_en)
        store_register(cfg_index, cfg_data);
      if (cmd.valid && cmd.ready) begin
        if (predict_update(cmd.opcode, longint'(cmd.volts), longint'(cmd.duration_ms),
                           want))
          pending_updates.push_back(want);
      end
    end
    updates_waiting <= pending_updates.size();
  end

endmodule

// ===== tb/sv/calibrated_dac_ramp_controller_test.sv =====
// ----------------------------------------------------------------------------
// calibrated_dac_ramp_controller_test
// Drives set, ramp and tick commands into the DAC ramp controller under
// several calibration settings and handshake idling patterns; the update
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module calibrated_dac_ramp_controller_test;
  import cdrc_pkg::*;

  localparam int     VOLT_BITS      = 20;
  localparam int     CLK_PERIOD     = 10;
  localparam int     DRAIN_CYCLES   = 100;
  localparam longint TIMEOUT_CYCLES = 600000;
  localparam longint VOLT_MAX       = (longint'(1) <<< (VOLT_BITS - 1)) - 1;
  localparam longint VOLT_MIN       = -VOLT_MAX - 1;
  localparam int     MAX_RAMP_TICKS = 200;

  // First of the opcodes that the block ignores.
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int heat_ms_per   = 5;
  int cool_ms_per   = 10;
  int mismatches;
  int updates_waiting;

  cdrc_cmd_if #(.VOLT_BITS(VOLT_BITS)) cmd ();
  cdrc_res_if #(.VOLT_BITS(VOLT_BITS)) res ();

  calibrated_dac_ramp_controller #(.VOLT_BITS(VOLT_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res)
  );

  cdrc_update_checker #(.VOLT_BITS(VOLT_BITS)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .res             (res),
    .mismatch_count  (mismatches),
    .updates_waiting (updates_waiting)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic longint pick_volts();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return VOLT_MAX;
    if (r < 10)
      return VOLT_MIN;
    if (r < 15)
      return longint'($urandom_range(0, 2)) - 1;
    if (r < 60)
      return longint'($urandom_range(0, 127 * 4096));
    return longint'($signed(VOLT_BITS'($urandom)));
  endfunction

  function automatic int unsigned pick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(0, 40);
    if (r < 90)
      return (r < 85) ? 0 : 65535;
    return $urandom_range(0, 65535);
  endfunction

  // Leaves valid high after the transfer so that back-to-back commands flow.
  task automatic send_command(logic [OPCODE_W-1:0] op, longint volts, int unsigned ms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd.valid       <= 1'b1;
    cmd.opcode      <= op;
    cmd.volts       <= volts[VOLT_BITS-1:0];
    cmd.duration_ms <= ms[DURATION_W-1:0];
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (op <= OP_TICK)
      items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_command(OP_TICK, pick_volts(), $urandom_range(0, 65535));
  endtask

  task automatic hold_until_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (updates_waiting != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, longint val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(longint gain_p, longint off_p, longint gain_l,
                               longint off_l, longint cap, int heat_p, int cool_p);
    write_register(CFG_GAIN_POWER, gain_p);
    write_register(CFG_OFFSET_POWER, off_p);
    write_register(CFG_GAIN_LIMIT, gain_l);
    write_register(CFG_OFFSET_LIMIT, off_l);
    write_register(CFG_SOFT_CAP, cap);
    write_register(CFG_HEAT_PERIOD, heat_p);
    write_register(CFG_COOL_PERIOD, cool_p);
    heat_ms_per = (heat_p == 0) ? 1 : heat_p;
    cool_ms_per = (cool_p == 0) ? 1 : cool_p;
  endtask

  // A ramp start followed by roughly enough ticks to finish it; some are cut
  // short so that the next command aborts the ramp.
  task automatic ramp_sequence(bit heat);
    int unsigned ms;
    int          n;
    ms = pick_ms();
    if (!heat)
      send_command(OP_SET_POWER, pick_volts(), $urandom_range(0, 65535));
    send_command(heat ? OP_HEAT_UP : OP_COOL_DOWN, pick_volts(), ms);
    n = ms + 2 * (heat ? heat_ms_per : cool_ms_per) + 2;
    if (n > MAX_RAMP_TICKS)
      n = MAX_RAMP_TICKS;
    if ($urandom_range(0, 3) == 0)
      n = $urandom_range(0, n);
    repeat (n) begin
      if ($urandom_range(0, 49) == 0)
        send_command(OP_UNUSED_LO + OPCODE_W'($urandom_range(0, 2)), pick_volts(),
                     $urandom_range(0, 65535));
      send_ticks(1);
    end
  endtask

  task automatic run_traffic(int n);
    int          stop_at;
    int unsigned r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 18)
        send_command(OP_SET_POWER, pick_volts(), $urandom_range(0, 65535));
      else if (r < 30)
        send_command(OP_SET_LIMIT, pick_volts(), $urandom_range(0, 65535));
      else if (r < 60)
        ramp_sequence(1'b1);
      else if (r < 85)
        ramp_sequence(1'b0);
      else if (r < 93)
        send_ticks($urandom_range(1, 5));
      else
        send_command(OP_UNUSED_LO + OPCODE_W'($urandom_range(0, 2)), pick_volts(),
                     $urandom_range(0, 65535));
      if ($urandom_range(0, 24) == 0)
        hold_until_drained();
    end
  endtask

  initial begin
    cmd.valid       = 1'b0;
    cmd.opcode      = OP_TICK;
    cmd.volts       = '0;
    cmd.duration_ms = '0;
    res.ready       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_GAIN_POWER;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: range ends of both channels, ignored opcodes, a one
    // step heat ramp that ends in an idle tick, and an aborted ramp.
    send_command(OP_SET_POWER, VOLT_MAX, 0);
    send_command(OP_SET_POWER, VOLT_MIN, 65535);
    send_command(OP_SET_LIMIT, VOLT_MAX, 1);
    send_command(OP_SET_LIMIT, VOLT_MIN, 0);
    for (int k = 0; k < 3; k++)
      send_command(OP_UNUSED_LO + OPCODE_W'(k), VOLT_MAX, 65535);
    send_command(OP_HEAT_UP, 24'h30000, 0);
    send_ticks(6);
    send_command(OP_HEAT_UP, 24'h50000, 10);
    send_ticks(2);
    send_command(OP_SET_LIMIT, 24'h20000, 1);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Extreme calibration with a zero cool period and a saturated heat ramp.
    load_settings(4194303, -4194304, 0, 4194303, VOLT_MIN, 1, 0);
    send_command(OP_SET_POWER, 24'h20000, 0);
    send_command(OP_COOL_DOWN, 0, 0);
    send_ticks(1);
    send_command(OP_HEAT_UP, VOLT_MAX, 65535);
    send_ticks(3);
    send_command(OP_SET_POWER, 24'h10000, 0);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          load_settings(32768, -20480, 16384, 8192, 400000, 3, 2);
        end
        1: begin
          send_idle_pct = 68;
          stall_pct     = 0;
          load_settings($urandom_range(4096, 65536), longint'($urandom_range(0, 800000)) - 400000,
                        $urandom_range(4096, 16384), longint'($urandom_range(0, 80000)) - 40000,
                        $urandom_range(0, 524287), 1, 255);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 68;
          load_settings(0, 4194303, 4194303, -4194304, VOLT_MAX,
                        $urandom_range(1, 8), $urandom_range(1, 8));
        end
        default: begin
          send_idle_pct = 30;
          stall_pct     = 30;
          load_settings($urandom_range(4096, 65536), longint'($urandom_range(0, 800000)) - 400000,
                        $urandom_range(4096, 16384), longint'($urandom_range(0, 80000)) - 40000,
                        $urandom_range(200000, 524287), 0, 4);
        end
      endcase
      // Ticks first, so a ramp left running carries on under the new periods.
      send_ticks(12);
      run_traffic(100);
      send_command(OP_HEAT_UP, pick_volts(), 20);
      send_ticks(3);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0)
      $display("calibrated_dac_ramp_controller_test passed");
    else
      $display("calibrated_dac_ramp_controller_test failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("calibrated_dac_ramp_controller_test failed");
    $finish;
  end

endmodule
